// ----- rtl/mipsz_pkg.sv -----
// mipsz_pkg: shared types, constants and format decode for the mip chain size block
// depends on nothing; used by every other file under rtl
package mipsz_pkg;

   localparam int MAX_DIM_LOG2 = 15;
   localparam int LEVEL_CNT    = MAX_DIM_LOG2 + 1;
   localparam int DIM_W        = 16;
   localparam int FMT_W        = 6;
   localparam int BYTES_W      = 51;
   localparam int LVL_W        = 5;
   localparam int SCALE_W      = 5;
   localparam int WH_W         = 2 * DIM_W;
   localparam int DS_W         = DIM_W + SCALE_W - 1;
   localparam int COST_W       = WH_W + DS_W;
   localparam int SUM_W        = COST_W + 1;
   localparam int FORMAT_COUNT = 42;

   localparam logic [BYTES_W-1:0] BYTES_CAP = {BYTES_W{1'b1}};

   localparam logic [FMT_W-1:0] FMT_UNKNOWN          = 6'd0;
   localparam logic [FMT_W-1:0] FMT_DXT1             = 6'd14;
   localparam logic [FMT_W-1:0] FMT_DXT3             = 6'd15;
   localparam logic [FMT_W-1:0] FMT_DXT5             = 6'd16;
   localparam logic [FMT_W-1:0] FMT_DXT1_ONEBITALPHA = 6'd21;
   localparam logic [FMT_W-1:0] FMT_ATI1N            = 6'd38;
   localparam logic [FMT_W-1:0] FMT_ATI2N            = 6'd39;
   localparam logic [FMT_W-1:0] FMT_DXT1_RUNTIME     = 6'd40;
   localparam logic [FMT_W-1:0] FMT_DXT5_RUNTIME     = 6'd41;

   localparam logic [SCALE_W-1:0] BC8_BYTES  = 5'd8;
   localparam logic [SCALE_W-1:0] BC16_BYTES = 5'd16;

   // bytes per pixel for uncompressed formats
   localparam logic [SCALE_W-1:0] PX_BYTES [FORMAT_COUNT] = '{
      5'd0, 5'd4, 5'd4, 5'd3, 5'd3, 5'd2, 5'd1, 5'd2, 5'd1, 5'd1, 5'd3,
      5'd3, 5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd4, 5'd2, 5'd2, 5'd2,
      5'd0, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8, 5'd4, 5'd4, 5'd12, 5'd16,
      5'd2, 5'd4, 5'd4, 5'd4, 5'd2, 5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0
   };

   typedef struct packed {
      logic [DIM_W-1:0] tex_width;
      logic [DIM_W-1:0] tex_height;
      logic [DIM_W-1:0] tex_depth;
      logic [FMT_W-1:0] format_code;
      logic             whole_chain;
   } req_type;

   typedef struct packed {
      logic [BYTES_W-1:0] total_bytes;
      logic [LVL_W-1:0]   level_count;
      logic               format_error;
   } rsp_type;

   typedef struct packed {
      logic               comp;
      logic [SCALE_W-1:0] scale;
      logic               err;
   } fmt_type;

   // dimension lane: one mip level's dims and the flags that travel with it
   typedef struct packed {
      logic [DIM_W-1:0]   w;
      logic [DIM_W-1:0]   h;
      logic [DIM_W-1:0]   d;
      logic               walk;
      logic               cost_en;
      logic               chain;
      logic               comp;
      logic [SCALE_W-1:0] scale;
   } dim_type;

   // sum lane: trails the dimension lane by each cell's multiply registers (wh_ff/ds_ff, then cost_ff)
   typedef struct packed {
      logic               tok;
      logic [BYTES_W-1:0] acc;
      logic [LVL_W-1:0]   lvl;
   } acc_type;

   function automatic fmt_type fmt_decode(input logic [FMT_W-1:0] fmt);
      fmt_type r;
      r.comp  = 1'b0;
      r.scale = '0;
      r.err   = 1'b0;
      if (fmt == FMT_UNKNOWN || fmt >= FMT_W'(FORMAT_COUNT)) begin
         r.err = 1'b1;
      end else begin
         case (fmt)
            FMT_DXT1, FMT_ATI1N, FMT_DXT1_RUNTIME: begin
               r.comp  = 1'b1;
               r.scale = BC8_BYTES;
            end
            FMT_DXT3, FMT_DXT5, FMT_ATI2N, FMT_DXT5_RUNTIME: begin
               r.comp  = 1'b1;
               r.scale = BC16_BYTES;
            end
            FMT_DXT1_ONEBITALPHA: begin
               r.comp = 1'b1;
               r.err  = 1'b1;
            end
            default: begin
               r.scale = PX_BYTES[fmt];
            end
         endcase
      end
      return r;
   endfunction

endpackage

// ----- rtl/mipsz_cell.sv -----
// mipsz_cell: one mip level of the chain; costs its level and halves the dims
// depends on mipsz_pkg
module mipsz_cell (
   input  logic              clock,
   input  logic              reset,
   input  mipsz_pkg::dim_type dim_in,
   input  mipsz_pkg::acc_type acc_in,
   output mipsz_pkg::dim_type dim_out,
   output mipsz_pkg::acc_type acc_out
);

   logic [mipsz_pkg::DIM_W-1:0]   aw, ah, ad;
   logic [mipsz_pkg::DIM_W-1:0]   hw, hh, hd;
   logic [mipsz_pkg::WH_W-1:0]    wh;
   logic [mipsz_pkg::SCALE_W-1:0] eff_scale;
   logic                          at_one;
   logic [mipsz_pkg::SUM_W-1:0]   sum;

   mipsz_pkg::dim_type            dim_out_ff, dim_out_in;
   logic [mipsz_pkg::WH_W-1:0]    wh_ff, wh_in;
   logic [mipsz_pkg::DS_W-1:0]    ds_ff, ds_in;
   logic [mipsz_pkg::COST_W-1:0]  cost_ff;
   logic                          walk1_ff, walk2_ff;
   logic                          tok_ff;
   logic [mipsz_pkg::BYTES_W-1:0] acc_ff, acc_in_sat;
   logic [mipsz_pkg::LVL_W-1:0]   lvl_ff, lvl_in;

   // block formats round 1..3 up to 4 on width and height, 2..3 up to 4 on depth
   always_comb begin
      aw = dim_in.w;
      ah = dim_in.h;
      ad = dim_in.d;
      if (dim_in.comp) begin
         if (dim_in.w != '0 && dim_in.w < 16'd4) aw = 16'd4;
         if (dim_in.h != '0 && dim_in.h < 16'd4) ah = 16'd4;
         if (dim_in.d > 16'd1 && dim_in.d < 16'd4) ad = 16'd4;
      end
   end

   always_comb begin
      wh        = mipsz_pkg::WH_W'(aw) * mipsz_pkg::WH_W'(ah);
      wh_in     = dim_in.comp ? (wh >> 4) : wh;
      eff_scale = dim_in.cost_en ? dim_in.scale : '0;
      ds_in     = mipsz_pkg::DS_W'(ad) * mipsz_pkg::DS_W'(eff_scale);
   end

   always_comb begin
      hw     = ((dim_in.w >> 1) == '0) ? 16'd1 : (dim_in.w >> 1);
      hh     = ((dim_in.h >> 1) == '0) ? 16'd1 : (dim_in.h >> 1);
      hd     = ((dim_in.d >> 1) == '0) ? 16'd1 : (dim_in.d >> 1);
      at_one = (dim_in.w == 16'd1) && (dim_in.h == 16'd1) && (dim_in.d == 16'd1);
      dim_out_in         = dim_in;
      dim_out_in.w       = hw;
      dim_out_in.h       = hh;
      dim_out_in.d       = hd;
      dim_out_in.walk    = dim_in.walk && !at_one;
      dim_out_in.cost_en = dim_in.cost_en && dim_in.chain && dim_in.walk && !at_one;
   end

   // saturating add of this level's cost
   always_comb begin
      sum        = mipsz_pkg::SUM_W'(acc_in.acc) + mipsz_pkg::SUM_W'(cost_ff);
      acc_in_sat = (sum > mipsz_pkg::SUM_W'(mipsz_pkg::BYTES_CAP)) ?
                   mipsz_pkg::BYTES_CAP : sum[mipsz_pkg::BYTES_W-1:0];
      lvl_in     = acc_in.lvl + mipsz_pkg::LVL_W'(walk2_ff);
   end

   always_ff @(posedge clock) begin
      dim_out_ff <= dim_out_in;
      wh_ff      <= wh_in;
      ds_ff      <= ds_in;
      walk1_ff   <= dim_in.walk;
      cost_ff    <= mipsz_pkg::COST_W'(wh_ff) * mipsz_pkg::COST_W'(ds_ff);
      walk2_ff   <= walk1_ff;
      acc_ff     <= acc_in_sat;
      lvl_ff     <= lvl_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= acc_in.tok;
      end
   end

   assign dim_out     = dim_out_ff;
   assign acc_out.tok = tok_ff;
   assign acc_out.acc = acc_ff;
   assign acc_out.lvl = lvl_ff;

endmodule

// ----- rtl/mip_chain_memory_size.sv -----
// mip_chain_memory_size: top level, a row of mip level cells with input and result registers
// depends on mipsz_pkg and mipsz_cell
//
//   channel  | ports                        | beat
//   ---------+------------------------------+------------------------------
//   request  | req_valid req_stall req_data | one texture description
//   response | rsp_valid rsp_stall rsp_data | bytes, level count, error
//
// one texture at a time: the beat is registered, go_ff, go1_ff and go2_ff hold the sum lane
// back for the multiply ahead of it, then it passes each of the sixteen level cells, then a
// holding register and the result register; the next beat can be taken once the result is valid.
// req_stall is high from acceptance until the result moves into the result register,
// so a new beat is taken while an earlier result still waits on rsp_stall.
// synchronous reset clears the busy flag, the tokens and both valid flags.
module mip_chain_memory_size (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mipsz_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mipsz_pkg::rsp_type rsp_data
);

   mipsz_pkg::dim_type dim_link [mipsz_pkg::LEVEL_CNT+1];
   mipsz_pkg::acc_type acc_link [mipsz_pkg::LEVEL_CNT+1];

   mipsz_pkg::fmt_type fmt;
   mipsz_pkg::dim_type src_ff, src_in;
   mipsz_pkg::rsp_type hold_ff, hold_in, rsp_ff;

   logic busy_ff, go_ff, go1_ff, go2_ff;
   logic err_ff, zero_ff;
   logic hold_valid_ff, rsp_valid_ff;
   logic req_take, rsp_free, hold_move;
   mipsz_pkg::acc_type chain_end;

   assign req_take  = req_valid && !busy_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign hold_move = hold_valid_ff && rsp_free;
   assign chain_end = acc_link[mipsz_pkg::LEVEL_CNT];

   always_comb begin
      fmt            = mipsz_pkg::fmt_decode(req_data.format_code);
      src_in.w       = req_data.tex_width;
      src_in.h       = req_data.tex_height;
      src_in.d       = (req_data.tex_depth == '0) ? 16'd1 : req_data.tex_depth;
      src_in.walk    = 1'b1;
      src_in.cost_en = 1'b1;
      src_in.chain   = req_data.whole_chain;
      src_in.comp    = fmt.comp;
      src_in.scale   = fmt.scale;
   end

   always_comb begin
      hold_in.total_bytes  = chain_end.acc;
      hold_in.level_count  = zero_ff ? '0 : chain_end.lvl;
      hold_in.format_error = err_ff;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         src_ff  <= src_in;
         err_ff  <= fmt.err;
         zero_ff <= (req_data.tex_width == '0) || (req_data.tex_height == '0);
      end
      if (chain_end.tok) begin
         hold_ff <= hold_in;
      end
      if (hold_move) begin
         rsp_ff <= hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         go_ff         <= 1'b0;
         go1_ff        <= 1'b0;
         go2_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         go_ff  <= req_take;
         go1_ff <= go_ff;
         go2_ff <= go1_ff;
         if (req_take) begin
            busy_ff <= 1'b1;
         end else if (hold_move) begin
            busy_ff <= 1'b0;
         end
         if (chain_end.tok) begin
            hold_valid_ff <= 1'b1;
         end else if (hold_move) begin
            hold_valid_ff <= 1'b0;
         end
         if (hold_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sum lane enters cell 0 through go_ff, go1_ff and go2_ff, behind its dims, when the first cost is ready
   assign dim_link[0] = src_ff;
   assign acc_link[0] = '{tok: go2_ff, acc: '0, lvl: '0};

   for (genvar i = 0; i < mipsz_pkg::LEVEL_CNT; i++) begin : g_cell
      mipsz_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .dim_in  (dim_link[i]),
         .acc_in  (acc_link[i]),
         .dim_out (dim_link[i+1]),
         .acc_out (acc_link[i+1])
      );
   end

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/mipsz_check.sv -----
// mipsz_check: port-level assertions for mip_chain_memory_size, bound to the top level
// depends on mipsz_pkg
module mipsz_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mipsz_pkg::rsp_type rsp_data
);

   // result beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // one texture in flight: an accepted beat closes the request side
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side open right after a beat");

   // bad formats never cost anything
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.format_error |-> rsp_data.total_bytes == '0)
      else $error("format error with nonzero bytes");

   a_lvl_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.level_count <= mipsz_pkg::LVL_W'(mipsz_pkg::LEVEL_CNT))
      else $error("level count beyond chain length");

   // no result comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind mip_chain_memory_size mipsz_check u_mipsz_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
